### sv/adcas_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the query micro-program for the ADC averaging block.
// Used by adcas_serial_alu and adc_average_and_scale; depends on nothing.
package adcas_pkg;

  localparam int CHANNEL_COUNT = 10;
  localparam int AVERAGE_SHIFT = 11;

  localparam int ACC_W      = 23;
  localparam int SAMPLE_W   = 12;
  localparam int CAL_W      = 12;
  localparam int CH_W       = 4;
  localparam int VALUE_W    = 16;
  localparam int WORD_W     = 32;
  localparam int IN_TDATA_W = CH_W + SAMPLE_W;
  localparam int PADDR_W    = 3;
  localparam int APB_DATA_W = 32;
  localparam int AVG_W      = ACC_W - AVERAGE_SHIFT;
  localparam int CH_IDX_W   = $clog2(CHANNEL_COUNT);
  localparam int STEP_W     = 4;
  localparam int K_W        = 13;

  localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(1526);

  localparam logic REG_VREF_CAL    = 1'b0;
  localparam logic OPERATION_ACC   = 1'b0;
  localparam logic OPERATION_QUERY = 1'b1;

  localparam logic [CH_W-1:0] CH_BATT_V    = CH_W'(0);
  localparam logic [CH_W-1:0] CH_BUS_V     = CH_W'(1);
  localparam logic [CH_W-1:0] CH_SUPPLY_V  = CH_W'(2);
  localparam logic [CH_W-1:0] CH_DISCHG_I  = CH_W'(3);
  localparam logic [CH_W-1:0] CH_CHG_I     = CH_W'(4);
  localparam logic [CH_W-1:0] CH_INT_THERM = CH_W'(6);
  localparam logic [CH_W-1:0] CH_FEEDBACK  = CH_W'(7);
  localparam int              REF_CHANNEL  = 9;

  localparam int K_REF_MV     = 3300;
  localparam int K_FULL_SCALE = 4095;
  localparam int K_DIVIDER    = 11;
  localparam int K_FB_NUM     = 4667;
  localparam int K_FB_DEN     = 1000;
  localparam int K_SENSE_GAIN = 330;
  localparam int K_SENSE_R    = 6800;
  localparam int K_MILLI      = 1000;
  localparam int K_SHUNT      = 30;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_END} uop_op_t;
  typedef enum logic [1:0] {SRC_CONST, SRC_REF, SRC_CHAN} uop_src_t;
  typedef enum logic [2:0] {KIND_VOLT, KIND_CURR, KIND_MV, KIND_FB, KIND_NONE} kind_t;

  typedef struct packed {
    uop_op_t        op;
    uop_src_t       src;
    logic [K_W-1:0] k;
  } uop_t;

  typedef struct packed {
    logic start;
    logic div;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  function automatic kind_t kind_of(logic [CH_W-1:0] ch);
    kind_t k;
    unique case (ch)
      CH_BATT_V, CH_BUS_V, CH_SUPPLY_V: k = KIND_VOLT;
      CH_DISCHG_I, CH_CHG_I:            k = KIND_CURR;
      CH_INT_THERM:                     k = KIND_MV;
      CH_FEEDBACK:                      k = KIND_FB;
      default:                          k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic uop_t uop_at(kind_t kind, logic [STEP_W-1:0] step);
    uop_t u;
    u = '{op: OP_END, src: SRC_CONST, k: '0};
    unique case (step)
      STEP_W'(0): u = '{op: OP_MUL, src: SRC_CONST, k: K_W'(K_REF_MV)};
      STEP_W'(1): u = '{op: OP_DIV, src: SRC_REF,   k: '0};
      STEP_W'(2): u = '{op: OP_MUL, src: SRC_CHAN,  k: '0};
      STEP_W'(3): u = '{op: OP_DIV, src: SRC_CONST, k: K_W'(K_FULL_SCALE)};
      STEP_W'(4): begin
        unique case (kind)
          KIND_VOLT: u = '{op: OP_MUL, src: SRC_CONST, k: K_W'(K_DIVIDER)};
          KIND_CURR: u = '{op: OP_MUL, src: SRC_CONST, k: K_W'(K_SENSE_GAIN)};
          KIND_FB:   u = '{op: OP_MUL, src: SRC_CONST, k: K_W'(K_FB_NUM)};
          default:   u = '{op: OP_END, src: SRC_CONST, k: '0};
        endcase
      end
      STEP_W'(5): begin
        unique case (kind)
          KIND_CURR: u = '{op: OP_DIV, src: SRC_CONST, k: K_W'(K_SENSE_R)};
          KIND_FB:   u = '{op: OP_DIV, src: SRC_CONST, k: K_W'(K_FB_DEN)};
          default:   u = '{op: OP_END, src: SRC_CONST, k: '0};
        endcase
      end
      STEP_W'(6): begin
        if (kind == KIND_CURR) begin
          u = '{op: OP_MUL, src: SRC_CONST, k: K_W'(K_MILLI)};
        end
      end
      STEP_W'(7): begin
        if (kind == KIND_CURR) begin
          u = '{op: OP_DIV, src: SRC_CONST, k: K_W'(K_SHUNT)};
        end
      end
      default: u = '{op: OP_END, src: SRC_CONST, k: '0};
    endcase
    return u;
  endfunction

endpackage

### sv/adcas_serial_alu.sv
`timescale 1ns / 1ps
// Bit-serial multiply (shift-add, wraps at 32 bits) and restoring divide unit.
// Depends on adcas_pkg.
module adcas_serial_alu (
  input  logic                             clk,
  input  logic                             rst,
  input  adcas_pkg::alu_cmd_t              cmd,
  input  logic [adcas_pkg::WORD_W-1:0]     opa,
  input  logic [adcas_pkg::WORD_W-1:0]     opb,
  output adcas_pkg::alu_rsp_t              rsp,
  output logic [adcas_pkg::WORD_W-1:0]     result
);
  import adcas_pkg::*;

  localparam int CNT_W = $clog2(WORD_W) + 1;

  typedef enum logic [2:0] {
    ALU_IDLE = 3'b001,
    ALU_MUL  = 3'b010,
    ALU_DIV  = 3'b100
  } alu_state_t;

  alu_state_t        state, state_next;
  logic [WORD_W-1:0] work, work_next;
  logic [WORD_W-1:0] side, side_next;
  logic [WORD_W-1:0] opnd, opnd_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              done, done_next;
  logic [WORD_W+1:0] trial;

  always_comb begin
    trial      = {1'b0, side, work[WORD_W-1]} - {2'b00, opnd};
    state_next = state;
    work_next  = work;
    side_next  = side;
    opnd_next  = opnd;
    cnt_next   = cnt;
    done_next  = 1'b0;
    unique case (state)
      ALU_IDLE: begin
        if (cmd.start) begin
          work_next  = cmd.div ? opa : '0;
          side_next  = cmd.div ? '0 : opa;
          opnd_next  = opb;
          cnt_next   = CNT_W'(WORD_W);
          state_next = cmd.div ? ALU_DIV : ALU_MUL;
        end
      end
      ALU_MUL: begin
        if (opnd == '0) begin
          done_next  = 1'b1;
          state_next = ALU_IDLE;
        end else begin
          if (opnd[0]) begin
            work_next = work + side;
          end
          side_next = side << 1;
          opnd_next = opnd >> 1;
        end
      end
      ALU_DIV: begin
        if (!trial[WORD_W+1]) begin
          side_next = trial[WORD_W-1:0];
          work_next = {work[WORD_W-2:0], 1'b1};
        end else begin
          side_next = {side[WORD_W-2:0], work[WORD_W-1]};
          work_next = {work[WORD_W-2:0], 1'b0};
        end
        cnt_next = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done_next  = 1'b1;
          state_next = ALU_IDLE;
        end
      end
      default: state_next = ALU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ALU_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    work <= work_next;
    side <= side_next;
    opnd <= opnd_next;
    cnt  <= cnt_next;
  end

  assign rsp.busy = (state != ALU_IDLE);
  assign rsp.done = done;
  assign result   = work;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("alu done held longer than one cycle");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start && !rsp.busy |=> rsp.busy)
    else $error("alu did not start on command");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ALU_DIV) |-> (cnt != '0))
    else $error("divide running with exhausted bit count");

endmodule

### sv/adc_average_and_scale.sv
`timescale 1ns / 1ps
// ADC channel averaging with reference-ratiometric scaling; depends on adcas_pkg
// and adcas_serial_alu. Sample beats may come back to back while no query is in progress.
// A query beat runs a micro-program on the bit-serial unit, with an issue and a wait state per
// step: each multiply runs until its remaining multiplier bits are zero, each divide over all 32 bits;
// a current-channel query runs the longest program, and a reference fault or unused kind runs none.
// Synchronous reset clears all accumulators and loads the calibration default.
module adc_average_and_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [adcas_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // channel, sample
  input  logic                                 s_axis_tuser,  // operation
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [adcas_pkg::VALUE_W-1:0]        m_axis_tdata,  // scaled_value
  output logic                                 m_axis_tuser,  // ref_error
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [adcas_pkg::PADDR_W-1:0]        paddr,
  input  logic [adcas_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [adcas_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import adcas_pkg::*;

  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNEL_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [ACC_W-1:0]   acc [CHANNEL_COUNT];
  logic [CAL_W-1:0]   cal;
  logic [STEP_W-1:0]  step;
  kind_t              kind_q;
  logic [AVG_W-1:0]   avg_ref_q, avg_ch_q;
  logic [WORD_W-1:0]  x;
  logic [VALUE_W-1:0] res_value;
  logic               res_err;
  logic               out_valid;

  logic               in_accept, in_op, ch_ok, out_free, reg_sel, cfg_write;
  logic [CH_W-1:0]    in_ch;
  logic [SAMPLE_W-1:0] in_sample;
  logic [CH_IDX_W-1:0] in_idx;
  logic [ACC_W-1:0]   acc_cur, acc_upd;
  logic [AVG_W-1:0]   avg_ch, avg_ref;
  kind_t              in_kind;
  uop_t               uop;
  logic [WORD_W-1:0]  operand_b, alu_result;
  alu_cmd_t           alu_cmd;
  alu_rsp_t           alu_rsp;

  assign in_op     = s_axis_tuser;
  assign in_ch     = s_axis_tdata[CH_W-1:0];
  assign in_sample = s_axis_tdata[CH_W +: SAMPLE_W];
  assign in_idx    = in_ch[CH_IDX_W-1:0];
  assign in_kind   = kind_of(in_ch);
  assign ch_ok     = ({1'b0, in_ch} < CH_LIMIT);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  assign acc_cur = acc[in_idx];
  assign acc_upd = acc_cur - {{AVERAGE_SHIFT{1'b0}}, acc_cur[ACC_W-1:AVERAGE_SHIFT]}
                 + {{(ACC_W-SAMPLE_W){1'b0}}, in_sample};
  assign avg_ch  = ch_ok ? acc_cur[ACC_W-1:AVERAGE_SHIFT] : '0;

  generate
    if (REF_CHANNEL < CHANNEL_COUNT) begin : g_ref
      localparam logic [CH_IDX_W-1:0] REF_IDX = CH_IDX_W'(REF_CHANNEL);
      assign avg_ref = acc[REF_IDX][ACC_W-1:AVERAGE_SHIFT];
    end else begin : g_no_ref
      assign avg_ref = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        acc[i] <= '0;
      end
    end else if (in_accept && in_op == OPERATION_ACC && ch_ok) begin
      acc[in_idx] <= acc_upd;
    end
  end

  assign uop = uop_at(kind_q, step);

  always_comb begin
    unique case (uop.src)
      SRC_REF:  operand_b = {{(WORD_W-AVG_W){1'b0}}, avg_ref_q};
      SRC_CHAN: operand_b = {{(WORD_W-AVG_W){1'b0}}, avg_ch_q};
      default:  operand_b = {{(WORD_W-K_W){1'b0}}, uop.k};
    endcase
  end

  assign alu_cmd.start = (state == ST_ISSUE) && (uop.op != OP_END);
  assign alu_cmd.div   = (uop.op == OP_DIV);

  adcas_serial_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .opa    (x),
    .opb    (operand_b),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && in_op == OPERATION_QUERY) begin
          if (avg_ref == '0 || in_kind == KIND_NONE) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE:  state_next = (uop.op == OP_END) ? ST_FINISH : ST_WAIT;
      ST_WAIT:   state_next = alu_rsp.done ? ST_ISSUE : ST_WAIT;
      ST_FINISH: state_next = out_free ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        avg_ref_q <= avg_ref;
        avg_ch_q  <= avg_ch;
        kind_q    <= in_kind;
        x         <= {{(WORD_W-CAL_W){1'b0}}, cal};
        step      <= '0;
        res_value <= '0;
        res_err   <= (avg_ref == '0);
      end
      ST_ISSUE: begin
        if (uop.op == OP_END) begin
          res_value <= x[VALUE_W-1:0];
        end
      end
      ST_WAIT: begin
        if (alu_rsp.done) begin
          x    <= alu_result;
          step <= step + STEP_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_axis_tdata <= res_value;
          m_axis_tuser <= res_err;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready && (reg_sel == REG_VREF_CAL);
  assign prdata    = (reg_sel == REG_VREF_CAL) ? {{(APB_DATA_W-CAL_W){1'b0}}, cal} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= CAL_RESET;
    end else if (cfg_write) begin
      cal <= pwdata[CAL_W-1:0];
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("reference fault beat carries nonzero value");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    alu_cmd.start |-> !alu_rsp.busy)
    else $error("alu started while busy");

  a_query_leaves: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_op == OPERATION_QUERY |=> (state != ST_IDLE))
    else $error("query beat accepted without leaving idle");

endmodule

### verif/adc_average_and_scale_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for adc_average_and_scale: stream beats in, scaled readings out.
// Keeps its own per-channel averages and calibration copy; depends on adcas_pkg and the RTL.
module adc_average_and_scale_tb;
  import adcas_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int LONG_HOLD      = 600;

  typedef struct {
    logic                op;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
  } adc_beat_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               ref_err;
  } reading_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;  // channel, sample
  logic                    s_axis_tuser = 1'b0;  // operation
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]      m_axis_tdata;  // scaled_value
  logic                    m_axis_tuser;  // ref_error
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  adc_average_and_scale u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [ACC_W-1:0] channel_acc [16];
  logic [CAL_W-1:0] cal_copy;
  adc_beat_t        pending_beats [$];
  reading_t         expected_readings [$];
  adc_beat_t        offered;
  int               beats_queued = 0;
  int               beats_sent = 0;
  int               results_checked = 0;
  int               mismatches = 0;
  int               tx_gap = 0;
  int               rx_hold = 0;
  int               rx_draw;
  int               idle_cycles = 0;
  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  function automatic bit [31:0] scale_for_kind(logic [CH_W-1:0] ch, bit [31:0] mv);
    case (ch)
      CH_BATT_V, CH_BUS_V, CH_SUPPLY_V: return mv * 32'd11;
      CH_DISCHG_I, CH_CHG_I:            return (((mv * 32'd330) / 32'd6800) * 32'd1000) / 32'd30;
      CH_INT_THERM:                     return mv;
      CH_FEEDBACK:                      return (mv * 32'd4667) / 32'd1000;
      default:                          return 32'd0;
    endcase
  endfunction

  // Fold a sample into its channel average, or predict the reading a query returns.
  function automatic void step_averager(adc_beat_t b);
    reading_t   r;
    bit [31:0]  avg_ref;
    bit [31:0]  avg;
    bit [31:0]  supply;
    bit [31:0]  mv;
    bit [31:0]  scaled;
    if (b.op == OPERATION_ACC) begin
      if (b.ch < CHANNEL_COUNT) begin
        channel_acc[b.ch] = channel_acc[b.ch] - (channel_acc[b.ch] >> AVERAGE_SHIFT) + b.sample;
      end
      return;
    end
    avg_ref = channel_acc[REF_CHANNEL] >> AVERAGE_SHIFT;
    if (avg_ref == 0) begin
      r.value   = '0;
      r.ref_err = 1'b1;
    end else begin
      supply    = (32'd3300 * cal_copy) / avg_ref;
      avg       = (b.ch < CHANNEL_COUNT) ? 32'(channel_acc[b.ch] >> AVERAGE_SHIFT) : 32'd0;
      mv        = (avg * supply) / 32'd4095;
      scaled    = scale_for_kind(b.ch, mv);
      r.value   = scaled[VALUE_W-1:0];
      r.ref_err = 1'b0;
    end
    expected_readings.push_back(r);
  endfunction

  task automatic queue_beat(logic op, int ch, int sample);
    adc_beat_t b;
    b.op     = op;
    b.ch     = CH_W'(ch);
    b.sample = SAMPLE_W'(sample);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_random(int count, int ref_cap, int query_pct);
    int r;
    int s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < query_pct) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9);
        queue_beat(OPERATION_QUERY, r, $urandom_range(0, 4095));
      end else begin
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        s = (s < 15) ? 4095 : (s < 25) ? 0 : $urandom_range(0, 4095);
        if (r < 25) begin
          queue_beat(OPERATION_ACC, REF_CHANNEL, $urandom_range(0, ref_cap));
        end else if (r < 30) begin
          queue_beat(OPERATION_ACC, $urandom_range(10, 15), s);
        end else begin
          queue_beat(OPERATION_ACC, $urandom_range(0, 8), s);
        end
      end
    end
  endtask

  task automatic apb_write(logic [CAL_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_VREF_CAL);
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cal_copy = value;
  endtask

  task automatic wait_for_idle();
    while (beats_sent != beats_queued || expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_averager(offered);
        beats_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          offered = pending_beats.pop_front();
          s_axis_tdata  <= {offered.sample, offered.ch};
          s_axis_tuser  <= offered.op;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
          tx_gap <= tx_burst ? 0 : $urandom_range(0, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("reading %0d/%0d with nothing expected",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        reading_t want;
        want = expected_readings.pop_front();
        if (m_axis_tdata !== want.value) begin
          report_mismatch($sformatf("scaled_value got %0d want %0d", m_axis_tdata, want.value));
        end
        if (m_axis_tuser !== want.ref_err) begin
          report_mismatch($sformatf("ref_error got %0b want %0b", m_axis_tuser, want.ref_err));
        end
      end
      results_checked++;
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      rx_draw = rx_burst ? 0 : $urandom_range(0, 9);
      if (results_checked == 40 || results_checked == 300) rx_draw = LONG_HOLD;
      rx_hold       <= rx_draw;
      m_axis_tready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= (rx_hold == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAIL adc_average_and_scale");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) channel_acc[i] = '0;
    cal_copy = CAL_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reference still empty, out-of-range channel, then each kind once the reference is live.
    queue_beat(OPERATION_QUERY, CH_BATT_V, 0);
    queue_beat(OPERATION_ACC, 15, 4095);
    queue_beat(OPERATION_QUERY, 15, 4095);
    queue_beat(OPERATION_ACC, REF_CHANNEL, 0);
    queue_beat(OPERATION_QUERY, REF_CHANNEL, 0);
    queue_beat(OPERATION_ACC, REF_CHANNEL, 4095);
    queue_beat(OPERATION_ACC, CH_BATT_V, 4095);
    queue_beat(OPERATION_ACC, CH_BUS_V, 2048);
    queue_beat(OPERATION_ACC, CH_SUPPLY_V, 1);
    queue_beat(OPERATION_ACC, CH_DISCHG_I, 4095);
    queue_beat(OPERATION_ACC, CH_CHG_I, 4095);
    queue_beat(OPERATION_ACC, 5, 4095);
    queue_beat(OPERATION_ACC, CH_INT_THERM, 4095);
    queue_beat(OPERATION_ACC, CH_FEEDBACK, 4095);
    queue_beat(OPERATION_ACC, 8, 4095);
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) queue_beat(OPERATION_QUERY, ch, 0);
    queue_beat(OPERATION_QUERY, 12, 0);
    wait_for_idle();

    apb_write(CAL_W'(0));
    queue_random(145, 4095, 30);
    wait_for_idle();
    apb_write(CAL_W'(4095));
    queue_random(145, 15, 20);
    wait_for_idle();
    apb_write(CAL_W'(1));
    queue_random(145, 4095, 30);
    wait_for_idle();
    apb_write(CAL_W'($urandom_range(2, 4094)));
    queue_random(145, 1, 15);
    wait_for_idle();
    apb_write(CAL_W'(2000));
    queue_random(145, 4095, 40);
    wait_for_idle();
    apb_write(CAL_W'(4095));
    queue_random(145, 3, 25);
    wait_for_idle();

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("PASS adc_average_and_scale");
    end else begin
      $display("FAIL adc_average_and_scale");
    end
    $finish;
  end

endmodule

### files.f
sv/adcas_pkg.sv
sv/adcas_serial_alu.sv
sv/adc_average_and_scale.sv
verif/adc_average_and_scale_tb.sv
